### rtl/core/iscg_pkg.sv
package iscg_pkg;

  localparam int unsigned QUARTER_TABLE_DEPTH = 16;
  localparam int unsigned STEP_BITS = 6;
  localparam int unsigned SAMPLE_W = 11;
  localparam int unsigned TIME_W = 32;

  // reciprocal constants for division by multiply and shift
  localparam logic [31:0] RECIP_DIV5 = 32'hCCCC_CCCD;  // shift 34
  localparam logic [31:0] RECIP_DIV25 = 32'h51EB_851F;  // shift 35
  localparam logic [31:0] RECIP_DIV125 = 32'h8312_6E98;  // shift 38
  localparam logic [31:0] CHIRP_PERIOD_MS = 32'd4000;
  localparam logic [31:0] CHIRP_SPAN_HZ = 32'd59;
  localparam logic [31:0] MILLI_DIV = 32'd125;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  function automatic sample_t quarter_value(input logic [3:0] off);
    sample_t v;
    case (off)
      4'd0:  v = 11'sd0;
      4'd1:  v = 11'sd98;
      4'd2:  v = 11'sd195;
      4'd3:  v = 11'sd290;
      4'd4:  v = 11'sd383;
      4'd5:  v = 11'sd471;
      4'd6:  v = 11'sd556;
      4'd7:  v = 11'sd634;
      4'd8:  v = 11'sd707;
      4'd9:  v = 11'sd773;
      4'd10: v = 11'sd831;
      4'd11: v = 11'sd881;
      4'd12: v = 11'sd924;
      4'd13: v = 11'sd957;
      4'd14: v = 11'sd981;
      default: v = 11'sd995;
    endcase
    return v;
  endfunction

  // one of 64 steps of the mirrored quarter wave
  function automatic sample_t step_value(input logic [STEP_BITS-1:0] s);
    logic [3:0] off;
    logic [3:0] mirror;
    sample_t v;
    off = s[3:0];
    mirror = 4'd15 - off;
    case (s[5:4])
      2'd0: v = quarter_value(off);
      2'd1: v = quarter_value(mirror);
      2'd2: v = -quarter_value(off);
      default: v = -quarter_value(mirror);
    endcase
    return v;
  endfunction

endpackage

### rtl/core/interpolated_sine_chirp_generator.sv
// requests: one at a time; in_ready_o is low from an accepted request with a new time until
//   its result moves to the output register, which waits while the output stalls; one shared
//   32x32 multiplier is used in 13 of 19 sequenced steps; a request with an unchanged time is
//   taken while idle and gives no result
// reset: rst_ni asynchronous, active low; clears last time, chirp phase and all valids
module interpolated_sine_chirp_generator
  import iscg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         time_ms_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [10:0]  sine_fast_o,
  output logic signed [10:0]  sine_slow_o,
  output logic signed [10:0]  chirp_sample_o
);

  // top-level sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  // sequencer steps, at most one multiply issued per step
  localparam logic [4:0] STEP_FAST_DIV  = 5'd0;   // (t << 10) / 5
  localparam logic [4:0] STEP_SLOW_DIV  = 5'd1;   // (t << 9) / 25
  localparam logic [4:0] STEP_PER_DIV   = 5'd2;   // t / 4000
  localparam logic [4:0] STEP_PER_MUL   = 5'd3;   // quotient * 4000
  localparam logic [4:0] STEP_PER_REM   = 5'd4;   // remainder within the sweep
  localparam logic [4:0] STEP_SPAN_MUL  = 5'd5;   // remainder * 59
  localparam logic [4:0] STEP_SPAN_DIV  = 5'd6;   // / 4000
  localparam logic [4:0] STEP_FREQ_MUL  = 5'd7;   // freq * elapsed
  localparam logic [4:0] STEP_ACC       = 5'd8;   // accumulate chirp phase
  localparam logic [4:0] STEP_MILLI_DIV = 5'd9;   // phase / 125
  localparam logic [4:0] STEP_MILLI_MUL = 5'd10;  // quotient * 125
  localparam logic [4:0] STEP_MILLI_REM = 5'd11;  // remainder
  localparam logic [4:0] STEP_FINE_DIV  = 5'd12;  // (rem << 9) / 125
  localparam logic [4:0] STEP_CHIRP_PH  = 5'd13;  // assemble chirp phase
  localparam logic [4:0] STEP_INT_FAST  = 5'd14;  // interpolate fast sine
  localparam logic [4:0] STEP_INT_SLOW  = 5'd15;
  localparam logic [4:0] STEP_INT_CHIRP = 5'd16;
  localparam logic [4:0] STEP_INT_LAST  = 5'd17;  // take chirp sample
  localparam logic [4:0] STEP_DELIVER   = 5'd18;  // move to output register

  logic        state_q, state_d;
  logic [4:0]  step_q, step_d;

  // architectural state
  logic [31:0] last_time_q;
  logic [31:0] chirp_phase_q;

  // per-request working registers
  logic [31:0] time_q;
  logic [31:0] delta_q;
  logic [63:0] prod_q;
  logic [11:0] tmp_q;
  logic [11:0] fast_ph_q;
  logic [11:0] slow_ph_q;
  logic [11:0] chirp_ph_q;
  logic [2:0]  milli_lo_q;
  sample_t     base_q;
  sample_t     fast_r_q;
  sample_t     slow_r_q;

  // output register
  logic        out_valid_q;
  sample_t     sine_fast_q;
  sample_t     sine_slow_q;
  sample_t     chirp_q;

  logic        in_req;
  logic        new_time;
  logic        out_free;

  // shared multiplier
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod_d;

  // interpolation operands
  logic [11:0]          int_ph;
  logic [5:0]           int_step;
  logic [5:0]           int_step_nx;
  sample_t              int_a;
  sample_t              int_b;
  logic signed [11:0]   int_diff;
  sample_t              int_sample;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_req     = in_valid_i && in_ready_o;
  assign new_time   = (time_ms_i != last_time_q);
  assign out_free   = !out_valid_q || out_ready_i;

  // phase being interpolated in this step
  always_comb begin
    case (step_q)
      STEP_INT_FAST: int_ph = fast_ph_q;
      STEP_INT_SLOW: int_ph = slow_ph_q;
      default:       int_ph = chirp_ph_q;
    endcase
  end

  assign int_step    = int_ph[11:6];
  assign int_step_nx = int_step + 6'd1;
  assign int_a       = step_value(int_step);
  assign int_b       = step_value(int_step_nx);
  assign int_diff    = 12'(int_b) - 12'(int_a);
  // low bits of the product arithmetically shifted by six, plus the step value
  assign int_sample  = base_q + sample_t'(prod_q[16:6]);

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      STEP_FAST_DIV: begin
        op_a = {time_q[21:0], 10'd0};
        op_b = RECIP_DIV5;
      end
      STEP_SLOW_DIV: begin
        op_a = {time_q[22:0], 9'd0};
        op_b = RECIP_DIV25;
      end
      STEP_PER_DIV: begin
        op_a = {5'd0, time_q[31:5]};
        op_b = RECIP_DIV125;
      end
      STEP_PER_MUL: begin
        op_a = {6'd0, prod_q[63:38]};
        op_b = CHIRP_PERIOD_MS;
      end
      STEP_SPAN_MUL: begin
        op_a = {20'd0, tmp_q};
        op_b = CHIRP_SPAN_HZ;
      end
      STEP_SPAN_DIV: begin
        op_a = {5'd0, prod_q[31:5]};
        op_b = RECIP_DIV125;
      end
      STEP_FREQ_MUL: begin
        // frequency in hz is one more than the scaled sweep position
        op_a = {25'd0, {1'b0, prod_q[43:38]} + 7'd1};
        op_b = delta_q;
      end
      STEP_MILLI_DIV: begin
        op_a = chirp_phase_q;
        op_b = RECIP_DIV125;
      end
      STEP_MILLI_MUL: begin
        op_a = {6'd0, prod_q[63:38]};
        op_b = MILLI_DIV;
      end
      STEP_FINE_DIV: begin
        op_a = {11'd0, tmp_q, 9'd0};
        op_b = RECIP_DIV125;
      end
      STEP_INT_FAST, STEP_INT_SLOW, STEP_INT_CHIRP: begin
        // signed difference times fraction, kept modulo 2^32
        op_a = {{20{int_diff[11]}}, int_diff};
        op_b = {26'd0, int_ph[5:0]};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = 64'(op_a) * 64'(op_b);

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_req && new_time) begin
          state_d = ST_CALC;
          step_d  = STEP_FAST_DIV;
        end
      end
      ST_CALC: begin
        if (step_q == STEP_DELIVER) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= STEP_FAST_DIV;
      last_time_q   <= '0;
      chirp_phase_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (in_req && new_time) begin
        last_time_q <= time_ms_i;
      end
      if (state_q == ST_CALC && step_q == STEP_ACC) begin
        chirp_phase_q <= chirp_phase_q + prod_q[31:0];
      end
      if (state_q == ST_CALC && step_q == STEP_DELIVER && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_req && new_time) begin
      time_q  <= time_ms_i;
      delta_q <= time_ms_i - last_time_q;
    end
    if (state_q == ST_CALC) begin
      prod_q <= prod_d;
      case (step_q)
        STEP_SLOW_DIV:  fast_ph_q  <= prod_q[45:34];
        STEP_PER_DIV:   slow_ph_q  <= prod_q[46:35];
        STEP_PER_REM:   tmp_q      <= 12'(time_q - prod_q[31:0]);
        STEP_MILLI_MUL: milli_lo_q <= prod_q[40:38];
        STEP_MILLI_REM: tmp_q      <= 12'(chirp_phase_q - prod_q[31:0]);
        // fine part is below 512, so it just fills the low nine bits
        STEP_CHIRP_PH:  chirp_ph_q <= {milli_lo_q, prod_q[46:38]};
        STEP_INT_FAST:  base_q     <= int_a;
        STEP_INT_SLOW: begin
          fast_r_q <= int_sample;
          base_q   <= int_a;
        end
        STEP_INT_CHIRP: begin
          slow_r_q <= int_sample;
          base_q   <= int_a;
        end
        STEP_INT_LAST:  base_q     <= int_sample;
        default: begin
        end
      endcase
    end
    if (state_q == ST_CALC && step_q == STEP_DELIVER && out_free) begin
      sine_fast_q <= fast_r_q;
      sine_slow_q <= slow_r_q;
      chirp_q     <= base_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sine_fast_o    = sine_fast_q;
  assign sine_slow_o    = sine_slow_q;
  assign chirp_sample_o = chirp_q;

endmodule

### rtl/core/iscg_checker.sv
module iscg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [31:0]        time_ms_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [10:0] sine_fast_o,
  input logic signed [10:0] sine_slow_o,
  input logic signed [10:0] chirp_sample_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sine_fast_o)
      && $stable(sine_slow_o) && $stable(chirp_sample_o))
    else $error("result changed while stalled");

  // stalled request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(time_ms_i))
    else $error("request changed while stalled");

  // samples never exceed the table peak
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sine_fast_o >= -11'sd995 && sine_fast_o <= 11'sd995
      && sine_slow_o >= -11'sd995 && sine_slow_o <= 11'sd995
      && chirp_sample_o >= -11'sd995 && chirp_sample_o <= 11'sd995)
    else $error("sample out of range");

  // a result only appears at the end of a busy computation
  a_busy_before_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without computation");

endmodule

bind interpolated_sine_chirp_generator iscg_checker u_iscg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .time_ms_i      (time_ms_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sine_fast_o    (sine_fast_o),
  .sine_slow_o    (sine_slow_o),
  .chirp_sample_o (chirp_sample_o)
);

### bench/tb_interpolated_sine_chirp_generator.sv
`timescale 1ns / 100ps

module tb_interpolated_sine_chirp_generator;
  import iscg_pkg::*;

  // cycles with no request moving in either direction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // margin after the last expected result to catch any stray results
  localparam int DRAIN_CYCLES = 40;

  // quarter wave of a sine, 16 points, full scale 1000
  localparam int QUARTER_WAVE [16] = '{
    0, 98, 195, 290, 383, 471, 556, 634, 707, 773, 831, 881, 924, 957, 981, 995
  };

  typedef struct packed {
    sample_t fast;
    sample_t slow;
    sample_t chirp;
  } sample_set_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [31:0] time_ms_i = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  sample_t     sine_fast_o;
  sample_t     sine_slow_o;
  sample_t     chirp_sample_o;

  interpolated_sine_chirp_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .time_ms_i      (time_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sine_fast_o    (sine_fast_o),
    .sine_slow_o    (sine_slow_o),
    .chirp_sample_o (chirp_sample_o)
  );

  // generator state as the testbench tracks it
  logic [31:0] last_tick = '0;
  logic [31:0] chirp_acc = '0;

  // sample sets still owed by the block, oldest first
  sample_set_t expected_sets_q[$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int ticks_sent = 0;
  int sets_checked = 0;
  int errors = 0;
  int idle_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // one of the 64 mirrored steps: bit 4 mirrors the offset, bit 5 negates
  function automatic int wave_step(input logic [5:0] s);
    int mag;
    mag = QUARTER_WAVE[s[4] ? 4'd15 - s[3:0] : s[3:0]];
    return s[5] ? -mag : mag;
  endfunction

  // linear interpolation between neighboring steps, slope rounded toward minus infinity
  function automatic sample_t interp_sine(input logic [31:0] phase);
    logic [5:0] nxt;
    int lo;
    int hi;
    int slope;
    nxt = phase[11:6] + 6'd1;
    lo = wave_step(phase[11:6]);
    hi = wave_step(nxt);
    slope = (hi - lo) * int'(phase[5:0]);
    return sample_t'(lo + (slope >>> 6));
  endfunction

  // advances the tracked state for one tick; returns 0 when the tick is unchanged
  function automatic bit predict_samples(input logic [31:0] now, output sample_set_t set);
    logic [31:0] elapsed;
    logic [31:0] scaled;
    logic [31:0] fast_ph;
    logic [31:0] slow_ph;
    logic [31:0] rate;
    logic [63:0] chirp_ph;
    set = '0;
    elapsed = now - last_tick;
    if (elapsed == 32'd0) return 1'b0;
    last_tick = now;
    // both products wrap at 32 bits before the divide
    scaled = now << 10;
    fast_ph = scaled / 32'd5;
    scaled = now << 9;
    slow_ph = scaled / 32'd25;
    // chirp rate in hz ramps 1..59 over each 4 s window
    rate = 32'd1 + ((now % 32'd4000) * 32'd59) / 32'd4000;
    chirp_acc = chirp_acc + rate * elapsed;
    // accumulator is in milli-periods of the chirp wave, rescale to 1/4096 period
    chirp_ph = ({32'd0, chirp_acc} * 64'd4096) / 64'd1000;
    set.fast = interp_sine(fast_ph);
    set.slow = interp_sine(slow_ph);
    set.chirp = interp_sine(chirp_ph[31:0]);
    return 1'b1;
  endfunction

  // offer one tick; valid stays up across back-to-back requests
  task automatic send_tick(input logic [31:0] t, output bit produced);
    sample_set_t set;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    time_ms_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    produced = predict_samples(t, set);
    if (produced) expected_sets_q.push_back(set);
    ticks_sent++;
  endtask

  task automatic check_field(input string name, input sample_t want, input sample_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // output side: random back-pressure at the phase's stall rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each delivered set against the oldest outstanding one
  always @(posedge clk_i) begin : result_check
    sample_set_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_sets_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual fast=%0d slow=%0d chirp=%0d",
                 $time, sine_fast_o, sine_slow_o, chirp_sample_o);
        errors++;
      end else begin
        want = expected_sets_q.pop_front();
        check_field("sine_fast", want.fast, sine_fast_o);
        check_field("sine_slow", want.slow, sine_slow_o);
        check_field("chirp_sample", want.chirp, chirp_sample_o);
        sets_checked++;
      end
    end
  end

  // hang detection: any accepted request on either side resets the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // time 0 right after reset matches the cleared last time, so repeats give nothing
  task automatic test_unchanged_time();
    bit got;
    send_tick(32'd0, got);
    send_tick(32'd0, got);
    send_tick(32'd1, got);
    send_tick(32'd1, got);
    send_tick(32'd2, got);
  endtask

  // multiply overflow edges, full-range wrap, and backward jumps
  task automatic test_overflow_and_wrap();
    bit got;
    send_tick(32'h003F_FFFF, got);
    send_tick(32'h0040_0000, got);
    send_tick(32'h007F_FFFF, got);
    send_tick(32'h0080_0000, got);
    send_tick(32'hFFFF_FFFF, got);
    send_tick(32'h0000_0000, got);
    send_tick(32'h8000_0000, got);
    send_tick(32'h0000_0005, got);
    send_tick(32'hAAAA_AAAA, got);
    send_tick(32'h5555_5555, got);
  endtask

  // chirp rate jumps from its top back to 1 hz at each 4000 ms boundary
  task automatic test_chirp_sweep();
    bit got;
    send_tick(32'd3998, got);
    send_tick(32'd3999, got);
    send_tick(32'd4000, got);
    send_tick(32'd4001, got);
    send_tick(32'd7999, got);
    send_tick(32'd8000, got);
    send_tick(32'd2000, got);
  endtask

  // realistic millisecond stream: mostly +1, some repeats, skips and small rewinds
  task automatic test_tick_stream(input int n);
    logic [31:0] t;
    int changed;
    int pick;
    bit got;
    t = $urandom();
    changed = 0;
    while (changed < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        t = t + 32'd1;
      end else if (pick >= 80 && pick < 95) begin
        t = t + $urandom_range(40, 2);
      end else if (pick >= 95) begin
        t = t - $urandom_range(4000, 1);
      end
      // 70..79 resend the same tick
      send_tick(t, got);
      if (got) changed++;
    end
  endtask

  // arbitrary timestamps over the whole 32-bit range, some repeated
  task automatic test_random_times(input int n);
    logic [31:0] t;
    int changed;
    bit got;
    t = '0;
    changed = 0;
    while (changed < n) begin
      if ($urandom_range(9) != 0) t = $urandom();
      send_tick(t, got);
      if (got) changed++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unchanged_time();
    test_overflow_and_wrap();
    test_chirp_sweep();

    // pacing phases: free flow, slow sender, slow receiver, light both
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    test_tick_stream(160);
    test_random_times(72);

    sender_idle_pct = 76;
    recv_stall_pct = 0;
    test_tick_stream(160);
    test_random_times(72);

    sender_idle_pct = 0;
    recv_stall_pct = 76;
    test_tick_stream(160);
    test_random_times(72);

    sender_idle_pct = 17;
    recv_stall_pct = 17;
    test_tick_stream(160);
    test_random_times(72);

    // drain what is still in flight, then watch for anything extra
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    while (expected_sets_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d timestamps (repeats, wraps, rewinds, chirp window edges included)",
             ticks_sent);
    $display("checked %0d sample sets under four handshake pacing mixes", sets_checked);
    if (errors == 0 && expected_sets_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/iscg_pkg.sv
rtl/core/interpolated_sine_chirp_generator.sv
rtl/core/iscg_checker.sv
bench/tb_interpolated_sine_chirp_generator.sv
